### rtl/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

  localparam int NLANE = 3;
  localparam int TAY_STEPS = 6;
  localparam int TAY_LAT = 3;
  localparam int SQRT_STEPS = 32;
  localparam int NSTG = 3 + TAY_STEPS * TAY_LAT + 1 + SQRT_STEPS + 2 + SQRT_STEPS + 1;

  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] PI_OVER_4 = 31'd843314857;
  localparam logic [30:0] PI_OVER_2 = 31'd1686629713;
  localparam logic [30:0] ANGLE_RESET = 31'd4992900;

  typedef struct packed {
    logic [30:0]        term;
    logic signed [32:0] sum;
    logic [29:0]        a2;
    logic               is_cos;
  } lane_t;

  typedef lane_t [NLANE-1:0] lane_vec_t;

  typedef struct packed {
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [2:0]  oct;
  } side_t;

  function automatic logic [7:0] taylor_div(input logic [2:0] step, input logic is_cos);
    logic [7:0] d;
    unique case ({is_cos, step})
      4'b0000: d = 8'd6;
      4'b0001: d = 8'd20;
      4'b0010: d = 8'd42;
      4'b0011: d = 8'd72;
      4'b0100: d = 8'd110;
      4'b0101: d = 8'd156;
      4'b1000: d = 8'd2;
      4'b1001: d = 8'd12;
      4'b1010: d = 8'd30;
      4'b1011: d = 8'd56;
      4'b1100: d = 8'd90;
      4'b1101: d = 8'd132;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] taylor_recip(input logic [2:0] step, input logic is_cos);
    logic [31:0] m;
    unique case ({is_cos, step})
      4'b0000: m = 32'd715827882;
      4'b0001: m = 32'd214748364;
      4'b0010: m = 32'd102261126;
      4'b0011: m = 32'd59652323;
      4'b0100: m = 32'd39045157;
      4'b0101: m = 32'd27531841;
      4'b1000: m = 32'd2147483648;
      4'b1001: m = 32'd357913941;
      4'b1010: m = 32'd143165576;
      4'b1011: m = 32'd76695844;
      4'b1100: m = 32'd47721858;
      4'b1101: m = 32'd32537631;
      default: m = 32'd2147483648;
    endcase
    return m;
  endfunction

endpackage

### rtl/pss_taylor_cell.sv
`timescale 1ns / 1ps

module pss_taylor_cell (
  input  logic              clk,
  input  logic              en,
  input  logic [2:0]        step,
  input  pss_pkg::lane_vec_t lanes_i,
  input  pss_pkg::side_t    side_i,
  output pss_pkg::lane_vec_t lanes_o,
  output pss_pkg::side_t    side_o
);

  logic [60:0]        a_prod_nxt [pss_pkg::NLANE];
  logic [60:0]        a_prod_r   [pss_pkg::NLANE];
  pss_pkg::lane_vec_t a_lane_r;
  pss_pkg::side_t     a_side_r;

  logic [62:0]        b_mul      [pss_pkg::NLANE];
  logic [30:0]        b_n_nxt    [pss_pkg::NLANE];
  logic [30:0]        b_q_nxt    [pss_pkg::NLANE];
  logic [30:0]        b_n_r      [pss_pkg::NLANE];
  logic [30:0]        b_q_r      [pss_pkg::NLANE];
  pss_pkg::lane_vec_t b_lane_r;
  pss_pkg::side_t     b_side_r;

  logic [30:0]        c_rem      [pss_pkg::NLANE];
  logic [30:0]        c_q        [pss_pkg::NLANE];
  logic [7:0]         c_d        [pss_pkg::NLANE];
  pss_pkg::lane_vec_t c_lane_nxt;
  pss_pkg::lane_vec_t c_lane_r;
  pss_pkg::side_t     c_side_r;

  always_comb begin
    for (int l = 0; l < pss_pkg::NLANE; l++) begin
      a_prod_nxt[l] = 61'(lanes_i[l].term) * 61'(lanes_i[l].a2);
      b_n_nxt[l] = a_prod_r[l][60:30];
      b_mul[l] = 63'(b_n_nxt[l]) *
                 63'(pss_pkg::taylor_recip(step, a_lane_r[l].is_cos));
      b_q_nxt[l] = b_mul[l][62:32];
    end
  end

  always_comb begin
    c_lane_nxt = b_lane_r;
    for (int l = 0; l < pss_pkg::NLANE; l++) begin
      c_d[l] = pss_pkg::taylor_div(step, b_lane_r[l].is_cos);
      c_rem[l] = b_n_r[l] - 31'(b_q_r[l] * 31'(c_d[l]));
      c_q[l] = b_q_r[l] + 31'(c_rem[l] >= 31'(c_d[l]));
      c_lane_nxt[l].term = c_q[l];
      if (step[0]) begin
        c_lane_nxt[l].sum = b_lane_r[l].sum + $signed({2'b00, c_q[l]});
      end else begin
        c_lane_nxt[l].sum = b_lane_r[l].sum - $signed({2'b00, c_q[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < pss_pkg::NLANE; l++) begin
        a_prod_r[l] <= a_prod_nxt[l];
        b_n_r[l]    <= b_n_nxt[l];
        b_q_r[l]    <= b_q_nxt[l];
      end
      a_lane_r <= lanes_i;
      a_side_r <= side_i;
      b_lane_r <= a_lane_r;
      b_side_r <= a_side_r;
      c_lane_r <= c_lane_nxt;
      c_side_r <= b_side_r;
    end
  end

  assign lanes_o = c_lane_r;
  assign side_o  = c_side_r;

endmodule

### rtl/pss_sqrt_cell.sv
`timescale 1ns / 1ps

module pss_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     step,
  input  logic [63:0]    v_i,
  input  logic [63:0]    res_i,
  input  pss_pkg::side_t side_i,
  output logic [63:0]    v_o,
  output logic [63:0]    res_o,
  output pss_pkg::side_t side_o
);

  logic [63:0]    bit_w;
  logic [63:0]    trial;
  logic [63:0]    v_nxt;
  logic [63:0]    res_nxt;
  logic [63:0]    v_r;
  logic [63:0]    res_r;
  pss_pkg::side_t side_r;

  always_comb begin
    bit_w = 64'd1 << (6'd62 - {step, 1'b0});
    trial = res_i + bit_w;
    if (v_i >= trial) begin
      v_nxt   = v_i - trial;
      res_nxt = (res_i >> 1) + bit_w;
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      res_r  <= res_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign res_o  = res_r;
  assign side_o = side_r;

endmodule

### rtl/pillbox_sunshape_ray_direction_unit.sv
`timescale 1ns / 1ps

// Fully pipelined pillbox sun ray generator: one transfer can enter every cycle while the
// output is not held; each direction passes the input registers, the six three-stage Taylor
// cells, the two 32-stage square root chains and the output register. A held output stalls
// the whole pipeline, so the input side stalls in the same cycle. The cone half-angle register
// resets to 0.00465 rad and should be written only while no transfer is in flight.
module pillbox_sunshape_ray_direction_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_u_azimuth,
  input  logic [31:0]        in_u_radial,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_dir_x,
  output logic signed [30:0] out_dir_y,
  output logic signed [31:0] out_dir_z
);

  localparam int NS = pss_pkg::NSTG;

  logic [30:0]   cfg_r;
  logic [NS-1:0] vld_r;
  logic          en;

  logic [31:0] s0_ua_r;
  logic [31:0] s0_ur_r;
  logic [30:0] s0_t_r;

  logic [2:0]  s1_oct_nxt;
  logic [29:0] s1_rr;
  logic [59:0] s1_prod;
  logic        s1_tcos_nxt;
  logic [30:0] s1_tp_full;
  logic [2:0]  s1_oct_r;
  logic [29:0] s1_a_r;
  logic [29:0] s1_tp_r;
  logic        s1_tcos_r;
  logic [31:0] s1_ur_r;

  logic [59:0]        s2_aa;
  logic [59:0]        s2_tt;
  pss_pkg::lane_vec_t s2_lane_nxt;
  pss_pkg::side_t     s2_side_nxt;
  pss_pkg::lane_vec_t s2_lane_r;
  pss_pkg::side_t     s2_side_r;

  pss_pkg::lane_vec_t tay_l [pss_pkg::TAY_STEPS+1];
  pss_pkg::side_t     tay_s [pss_pkg::TAY_STEPS+1];

  logic [30:0]    c_sum [pss_pkg::NLANE];
  logic [63:0]    c_v_r;
  pss_pkg::side_t c_side_r;

  logic [63:0]    q1_v   [pss_pkg::SQRT_STEPS+1];
  logic [63:0]    q1_res [pss_pkg::SQRT_STEPS+1];
  pss_pkg::side_t q1_s   [pss_pkg::SQRT_STEPS+1];

  logic [62:0]    ss_prod;
  logic [30:0]    ss_s_r;
  pss_pkg::side_t ss_side_r;

  logic           sp_swap;
  logic [30:0]    sp_sp;
  logic [30:0]    sp_cp;
  logic [61:0]    sp_xp;
  logic [61:0]    sp_zp;
  logic [61:0]    sp_sq;
  logic [30:0]    sp_s2;
  logic [63:0]    sp_v_r;
  pss_pkg::side_t sp_side_r;

  logic [63:0]    q2_v   [pss_pkg::SQRT_STEPS+1];
  logic [63:0]    q2_res [pss_pkg::SQRT_STEPS+1];
  pss_pkg::side_t q2_s   [pss_pkg::SQRT_STEPS+1];

  logic [30:0]        o_xm;
  logic [30:0]        o_zm;
  logic [2:0]         o_oct;
  logic signed [31:0] o_x_r;
  logic signed [30:0] o_y_r;
  logic signed [31:0] o_z_r;

  function automatic logic [30:0] clamp_sum(input logic signed [32:0] v);
    logic [30:0] r;
    if (v < 33'sd0) begin
      r = 31'd0;
    end else if (v > $signed({2'b00, pss_pkg::Q30_ONE})) begin
      r = pss_pkg::Q30_ONE;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  assign en       = !(vld_r[NS-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pss_pkg::ANGLE_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (en) begin
        vld_r <= {vld_r[NS-2:0], in_valid};
      end
    end
  end

  always_comb begin
    s1_oct_nxt  = s0_ua_r[31:29];
    s1_rr       = s1_oct_nxt[0] ? (30'h2000_0000 - {1'b0, s0_ua_r[28:0]})
                                : {1'b0, s0_ua_r[28:0]};
    s1_prod     = 60'(s1_rr) * 60'(pss_pkg::PI_OVER_4);
    s1_tcos_nxt = s0_t_r > pss_pkg::PI_OVER_4;
    s1_tp_full  = s1_tcos_nxt ? (pss_pkg::PI_OVER_2 - s0_t_r) : s0_t_r;
  end

  always_comb begin
    s2_aa = 60'(s1_a_r) * 60'(s1_a_r);
    s2_tt = 60'(s1_tp_r) * 60'(s1_tp_r);
    s2_lane_nxt[0].term   = s1_tcos_r ? pss_pkg::Q30_ONE : {1'b0, s1_tp_r};
    s2_lane_nxt[0].sum    = $signed({2'b00, s2_lane_nxt[0].term});
    s2_lane_nxt[0].a2     = s2_tt[59:30];
    s2_lane_nxt[0].is_cos = s1_tcos_r;
    s2_lane_nxt[1].term   = {1'b0, s1_a_r};
    s2_lane_nxt[1].sum    = $signed({3'b000, s1_a_r});
    s2_lane_nxt[1].a2     = s2_aa[59:30];
    s2_lane_nxt[1].is_cos = 1'b0;
    s2_lane_nxt[2].term   = pss_pkg::Q30_ONE;
    s2_lane_nxt[2].sum    = $signed({2'b00, pss_pkg::Q30_ONE});
    s2_lane_nxt[2].a2     = s2_aa[59:30];
    s2_lane_nxt[2].is_cos = 1'b1;
    s2_side_nxt.p0  = s1_ur_r;
    s2_side_nxt.p1  = '0;
    s2_side_nxt.p2  = '0;
    s2_side_nxt.oct = s1_oct_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ua_r   <= in_u_azimuth;
      s0_ur_r   <= in_u_radial;
      s0_t_r    <= (cfg_r > pss_pkg::PI_OVER_2) ? pss_pkg::PI_OVER_2 : cfg_r;
      s1_oct_r  <= s1_oct_nxt;
      s1_a_r    <= s1_prod[58:29];
      s1_tp_r   <= s1_tp_full[29:0];
      s1_tcos_r <= s1_tcos_nxt;
      s1_ur_r   <= s0_ur_r;
      s2_lane_r <= s2_lane_nxt;
      s2_side_r <= s2_side_nxt;
    end
  end

  assign tay_l[0] = s2_lane_r;
  assign tay_s[0] = s2_side_r;

  for (genvar g = 0; g < pss_pkg::TAY_STEPS; g++) begin : g_tay
    pss_taylor_cell u_cell (
      .clk     (clk),
      .en      (en),
      .step    (3'(g)),
      .lanes_i (tay_l[g]),
      .side_i  (tay_s[g]),
      .lanes_o (tay_l[g+1]),
      .side_o  (tay_s[g+1])
    );
  end

  always_comb begin
    for (int l = 0; l < pss_pkg::NLANE; l++) begin
      c_sum[l] = clamp_sum(tay_l[pss_pkg::TAY_STEPS][l].sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_v_r        <= {tay_s[pss_pkg::TAY_STEPS].p0, 32'd0};
      c_side_r.p0  <= {1'b0, c_sum[0]};
      c_side_r.p1  <= {1'b0, c_sum[1]};
      c_side_r.p2  <= {1'b0, c_sum[2]};
      c_side_r.oct <= tay_s[pss_pkg::TAY_STEPS].oct;
    end
  end

  assign q1_v[0]   = c_v_r;
  assign q1_res[0] = '0;
  assign q1_s[0]   = c_side_r;

  for (genvar g = 0; g < pss_pkg::SQRT_STEPS; g++) begin : g_sq1
    pss_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .step   (5'(g)),
      .v_i    (q1_v[g]),
      .res_i  (q1_res[g]),
      .side_i (q1_s[g]),
      .v_o    (q1_v[g+1]),
      .res_o  (q1_res[g+1]),
      .side_o (q1_s[g+1])
    );
  end

  assign ss_prod = 63'(q1_s[pss_pkg::SQRT_STEPS].p0[30:0]) *
                   63'(q1_res[pss_pkg::SQRT_STEPS][31:0]);

  always_comb begin
    sp_swap = ss_side_r.oct[0] ^ ss_side_r.oct[1];
    sp_sp   = sp_swap ? ss_side_r.p2[30:0] : ss_side_r.p1[30:0];
    sp_cp   = sp_swap ? ss_side_r.p1[30:0] : ss_side_r.p2[30:0];
    sp_xp   = 62'(ss_s_r) * 62'(sp_sp);
    sp_zp   = 62'(ss_s_r) * 62'(sp_cp);
    sp_sq   = 62'(ss_s_r) * 62'(ss_s_r);
    sp_s2   = (sp_sq[60:30] > pss_pkg::Q30_ONE) ? pss_pkg::Q30_ONE : sp_sq[60:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss_s_r        <= ss_prod[62:32];
      ss_side_r     <= q1_s[pss_pkg::SQRT_STEPS];
      sp_v_r        <= {3'b000, pss_pkg::Q30_ONE - sp_s2, 30'd0};
      sp_side_r.p0  <= {1'b0, sp_xp[60:30]};
      sp_side_r.p1  <= {1'b0, sp_zp[60:30]};
      sp_side_r.p2  <= '0;
      sp_side_r.oct <= ss_side_r.oct;
    end
  end

  assign q2_v[0]   = sp_v_r;
  assign q2_res[0] = '0;
  assign q2_s[0]   = sp_side_r;

  for (genvar g = 0; g < pss_pkg::SQRT_STEPS; g++) begin : g_sq2
    pss_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .step   (5'(g)),
      .v_i    (q2_v[g]),
      .res_i  (q2_res[g]),
      .side_i (q2_s[g]),
      .v_o    (q2_v[g+1]),
      .res_o  (q2_res[g+1]),
      .side_o (q2_s[g+1])
    );
  end

  assign o_xm  = q2_s[pss_pkg::SQRT_STEPS].p0[30:0];
  assign o_zm  = q2_s[pss_pkg::SQRT_STEPS].p1[30:0];
  assign o_oct = q2_s[pss_pkg::SQRT_STEPS].oct;

  always_ff @(posedge clk) begin
    if (en) begin
      o_x_r <= o_oct[2] ? $signed(32'd0 - {1'b0, o_xm}) : $signed({1'b0, o_xm});
      o_y_r <= $signed(31'd0 - q2_res[pss_pkg::SQRT_STEPS][30:0]);
      o_z_r <= (o_oct[1] ^ o_oct[2]) ? $signed(32'd0 - {1'b0, o_zm})
                                     : $signed({1'b0, o_zm});
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_dir_x = o_x_r;
  assign out_dir_y = o_y_r;
  assign out_dir_z = o_z_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_y_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dir_y <= 31'sd0)
    else $error("Direction y component is positive.");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= 32'sd1073741824 && out_dir_x >= -32'sd1073741824))
    else $error("Direction x component out of range.");

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_z <= 32'sd1073741824 && out_dir_z >= -32'sd1073741824))
    else $error("Direction z component out of range.");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 89;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 630;

  typedef struct packed {
    logic [31:0] u_azimuth;
    logic [31:0] u_radial;
  } ray_seed_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [30:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_dir_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_u_azimuth = '0;
  logic [31:0] in_u_radial = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_dir_x;
  logic signed [30:0] out_dir_y;
  logic signed [31:0] out_dir_z;

  ray_seed_t seed_queue[$];
  ray_dir_t expected_dirs[$];
  logic [30:0] half_angle = pss_pkg::ANGLE_RESET;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  int failures = 0;
  longint cycles = 0;

  pillbox_sunshape_ray_direction_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_u_azimuth(in_u_azimuth),
    .in_u_radial(in_u_radial), .out_valid(out_valid), .out_stall(out_stall),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned series_sum(longint unsigned first,
                                                 longint unsigned a2, int k0);
    longint unsigned term;
    longint total;
    bit subtract;
    term = first;
    total = longint'(first);
    subtract = 1'b1;
    for (int k = k0; k <= k0 + 11; k += 2) begin
      term = ((term * a2) >> 30) / longint'(k * (k - 1));
      total = subtract ? total - longint'(term) : total + longint'(term);
      subtract = !subtract;
    end
    if (total < 0) total = 0;
    if (total > longint'(pss_pkg::Q30_ONE)) total = longint'(pss_pkg::Q30_ONE);
    return longint'(total);
  endfunction

  function automatic longint unsigned sine_q30(longint unsigned a);
    return series_sum(a, (a * a) >> 30, 3);
  endfunction

  function automatic longint unsigned cosine_q30(longint unsigned a);
    return series_sum(64'(pss_pkg::Q30_ONE), (a * a) >> 30, 2);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_dir_t predict_direction(ray_seed_t seed, logic [30:0] angle);
    longint unsigned t, sin_max, sq, s, s2, ymag, r, a, sa, ca, sp, cp, xm, zm;
    logic [2:0] octant;
    bit sp_neg, cp_neg;
    ray_dir_t d;
    t = angle;
    if (t > pss_pkg::PI_OVER_2) t = pss_pkg::PI_OVER_2;
    sin_max = (t > pss_pkg::PI_OVER_4) ? cosine_q30(pss_pkg::PI_OVER_2 - t) : sine_q30(t);
    sq = int_sqrt(64'(seed.u_radial) << 32);
    s = (sin_max * sq) >> 32;
    s2 = (s * s) >> 30;
    if (s2 > pss_pkg::Q30_ONE) s2 = pss_pkg::Q30_ONE;
    ymag = int_sqrt((64'(pss_pkg::Q30_ONE) - s2) << 30);
    octant = seed.u_azimuth[31:29];
    r = seed.u_azimuth[28:0];
    if (octant[0]) r = (64'd1 << 29) - r;
    a = (r * pss_pkg::PI_OVER_4) >> 29;
    sa = sine_q30(a);
    ca = cosine_q30(a);
    sp = (octant == 1 || octant == 2 || octant == 5 || octant == 6) ? ca : sa;
    cp = (octant == 1 || octant == 2 || octant == 5 || octant == 6) ? sa : ca;
    sp_neg = octant >= 4;
    cp_neg = octant >= 2 && octant <= 5;
    xm = (s * sp) >> 30;
    zm = (s * cp) >> 30;
    d.dir_x = sp_neg ? -32'(xm) : 32'(xm);
    d.dir_y = -31'(ymag);
    d.dir_z = cp_neg ? -32'(zm) : 32'(zm);
    return d;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sender side.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_dirs.push_back(predict_direction({in_u_azimuth, in_u_radial},
                                                  half_angle));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (seed_queue.size() > 0 && $urandom_range(0, 5) != 0) begin
          ray_seed_t next;
          next = seed_queue.pop_front();
          in_valid <= 1'b1;
          in_u_azimuth <= next.u_azimuth;
          in_u_radial <= next.u_radial;
          if ($urandom_range(0, 9) == 0) begin
            gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_dirs.size() == 0) begin
          $error("transfer with no expected direction");
          failures++;
        end else begin
          ray_dir_t e;
          e = expected_dirs.pop_front();
          if (out_dir_x !== e.dir_x) begin
            $error("dir_x expected %0d actual %0d", e.dir_x, out_dir_x);
            failures++;
          end
          if (out_dir_y !== e.dir_y) begin
            $error("dir_y expected %0d actual %0d", e.dir_y, out_dir_y);
            failures++;
          end
          if (out_dir_z !== e.dir_z) begin
            $error("dir_z expected %0d actual %0d", e.dir_z, out_dir_z);
            failures++;
          end
        end
      end
      if (hold_request && hold_left == 0) begin
        hold_left <= 300;
        out_stall <= 1'b1;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_left == 1) begin
        hold_left <= 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0) begin
          stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 50)
                                                    : $urandom_range(1, 3);
        end
      end
    end
  end

  task automatic wait_idle();
    while (seed_queue.size() > 0 || in_valid || expected_dirs.size() > 0) @(negedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_half_angle(logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    half_angle = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_random_seeds(int count);
    for (int i = 0; i < count; i++) begin
      seed_queue.push_back({32'($urandom), 32'($urandom)});
    end
  endtask

  initial begin
    logic [30:0] angles[6];
    angles = '{31'd0, 31'd843314857, 31'd1686629713, 31'h7FFFFFFF, 31'd843314858,
               31'd1200000000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int o = 0; o < 8; o++) begin
      seed_queue.push_back({3'(o), 29'd0, 32'hFFFFFFFF});
      seed_queue.push_back({3'(o), 29'h1FFFFFFF, 32'd0});
    end
    seed_queue.push_back({32'h00000000, 32'h00000000});
    seed_queue.push_back({32'hFFFFFFFF, 32'hFFFFFFFF});
    seed_queue.push_back({32'h55555555, 32'hAAAAAAAA});
    seed_queue.push_back({32'hAAAAAAAA, 32'h55555555});
    seed_queue.push_back({32'h20000000, 32'h80000000});
    add_random_seeds(100);
    wait_idle();

    foreach (angles[i]) begin
      write_half_angle(angles[i]);
      add_random_seeds(RANDOM_ITEMS / 7);
      if (i == 2) begin
        hold_request = 1'b1;
        repeat (20) @(posedge clk);
        hold_request = 1'b0;
      end
      wait_idle();
    end
    write_half_angle(pss_pkg::ANGLE_RESET);
    add_random_seeds(RANDOM_ITEMS / 7);
    wait_idle();

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
